// ----- rtl/core/egd_pkg.sv -----
// Shared types and register codes for the ElGamal digit encryptor.
`default_nettype none

package egd_pkg;

    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_MODULUS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GENERATOR  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PUB_KEY    = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQ1,
        ST_MUL1,
        ST_SQ2,
        ST_MUL2,
        ST_LAST,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

// ----- rtl/core/elgamal_encrypt_digit.sv -----
// Top level of the ElGamal digit encryptor: config registers, sequencer, output register.
`default_nettype none

// Computes shared_part = g^k mod p and masked_part = y^k * m mod p for each input
// transfer, with p, g and y taken from the config registers (write them only while
// idle). A single bit-serial modular multiplier does all the work: an item needs
// 2*WORD_BITS squarings, one extra multiply per set bit of k in each ladder, and one
// final multiply, i.e. between (2*WORD_BITS + 1) and (4*WORD_BITS + 1) multiplies.
// A zero modulus skips the ladders and returns zeros. The input side is not ready
// while an item is in work; the finished result sits in an output register, so the
// next item is taken while it waits.
module elgamal_encrypt_digit #(
    parameter int unsigned WORD_BITS = 32
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_wr_en,
    input  wire logic [egd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [WORD_BITS-1:0]            i_cfg_data,
    input  wire logic                            i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // message_digit, ephemeral_key
    input  wire logic [((2*WORD_BITS+7)/8)*8-1:0] i_s_axis_tdata,
    output logic                                 o_m_axis_tvalid,
    input  wire logic                            i_m_axis_tready,
    // shared_part, masked_part
    output logic [((2*WORD_BITS+7)/8)*8-1:0]     o_m_axis_tdata
);

    localparam int unsigned DATA_W = ((2*WORD_BITS+7)/8)*8;

    logic [WORD_BITS-1:0] r_modulus;
    logic [WORD_BITS-1:0] r_generator;
    logic [WORD_BITS-1:0] r_pub_key;
    logic                 r_out_valid;
    logic [DATA_W-1:0]    r_out_data;

    logic                 mm_start;
    logic [WORD_BITS-1:0] mm_a;
    logic [WORD_BITS-1:0] mm_b;
    logic                 mm_done;
    logic [WORD_BITS-1:0] mm_result;
    logic                 res_valid;
    logic                 res_ready;
    logic [WORD_BITS-1:0] c1;
    logic [WORD_BITS-1:0] c2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus   <= WORD_BITS'(3);
            r_generator <= WORD_BITS'(2);
            r_pub_key   <= WORD_BITS'(1);
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                egd_pkg::CFG_MODULUS:   r_modulus   <= i_cfg_data;
                egd_pkg::CFG_GENERATOR: r_generator <= i_cfg_data;
                egd_pkg::CFG_PUB_KEY:   r_pub_key   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    egd_mulmod #(
        .WORD_BITS (WORD_BITS)
    ) u_mulmod (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (mm_start),
        .i_a      (mm_a),
        .i_b      (mm_b),
        .i_p      (r_modulus),
        .o_done   (mm_done),
        .o_result (mm_result)
    );

    egd_ctrl #(
        .WORD_BITS (WORD_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .i_m         (i_s_axis_tdata[WORD_BITS-1:0]),
        .i_k         (i_s_axis_tdata[2*WORD_BITS-1:WORD_BITS]),
        .i_p         (r_modulus),
        .i_g         (r_generator),
        .i_y         (r_pub_key),
        .o_mm_start  (mm_start),
        .o_mm_a      (mm_a),
        .o_mm_b      (mm_b),
        .i_mm_done   (mm_done),
        .i_mm_result (mm_result),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_c1        (c1),
        .o_c2        (c2)
    );

    assign res_ready = !r_out_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out_data <= DATA_W'({c2, c1});
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule

`default_nettype wire

// ----- rtl/core/egd_mulmod.sv -----
// Bit-serial modular multiplier: shift-and-add, one multiplier bit per cycle.
`default_nettype none

module egd_mulmod #(
    parameter int unsigned WORD_BITS = 32
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic [WORD_BITS-1:0] i_a,
    input  wire logic [WORD_BITS-1:0] i_b,
    input  wire logic [WORD_BITS-1:0] i_p,
    output logic                      o_done,
    output logic [WORD_BITS-1:0]      o_result
);

    localparam int unsigned CNT_W = $clog2(WORD_BITS);

    logic                 r_busy;
    logic                 r_done;
    logic [CNT_W-1:0]     r_cnt;
    logic [WORD_BITS-1:0] r_acc;
    logic [WORD_BITS-1:0] r_a;
    logic [WORD_BITS-1:0] r_b;

    logic [WORD_BITS:0]   p_ext;
    logic [WORD_BITS:0]   dbl;
    logic [WORD_BITS:0]   dbl_red;
    logic [WORD_BITS:0]   sum;
    logic [WORD_BITS:0]   sum_red;
    logic [WORD_BITS-1:0] n_acc;

    // acc = (2*acc mod p + bit*a) mod p
    always_comb begin
        p_ext   = {1'b0, i_p};
        dbl     = {r_acc, 1'b0};
        dbl_red = (dbl >= p_ext) ? (dbl - p_ext) : dbl;
        sum     = dbl_red + (r_b[WORD_BITS-1] ? {1'b0, r_a} : '0);
        sum_red = (sum >= p_ext) ? (sum - p_ext) : sum;
        n_acc   = sum_red[WORD_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_a   <= i_a;
            r_b   <= i_b;
            r_cnt <= CNT_W'(WORD_BITS - 1);
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_b   <= {r_b[WORD_BITS-2:0], 1'b0};
            r_cnt <= r_cnt - 1'b1;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_acc;

endmodule

`default_nettype wire

// ----- rtl/core/egd_ctrl.sv -----
// Sequencer: two interleaved square-and-multiply ladders on one shared multiplier.
`default_nettype none

module egd_ctrl #(
    parameter int unsigned WORD_BITS = 32
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic [WORD_BITS-1:0] i_m,
    input  wire logic [WORD_BITS-1:0] i_k,
    input  wire logic [WORD_BITS-1:0] i_p,
    input  wire logic [WORD_BITS-1:0] i_g,
    input  wire logic [WORD_BITS-1:0] i_y,
    output logic                      o_mm_start,
    output logic [WORD_BITS-1:0]      o_mm_a,
    output logic [WORD_BITS-1:0]      o_mm_b,
    input  wire logic                 i_mm_done,
    input  wire logic [WORD_BITS-1:0] i_mm_result,
    output logic                      o_res_valid,
    input  wire logic                 i_res_ready,
    output logic [WORD_BITS-1:0]      o_c1,
    output logic [WORD_BITS-1:0]      o_c2
);

    localparam int unsigned CNT_W = $clog2(WORD_BITS);

    egd_pkg::t_state      r_state, n_state;
    logic                 r_wait, n_wait;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic [WORD_BITS-1:0] r_k, n_k;
    logic [WORD_BITS-1:0] r_m, n_m;
    logic [WORD_BITS-1:0] r_acc1, n_acc1;
    logic [WORD_BITS-1:0] r_acc2, n_acc2;
    logic [WORD_BITS-1:0] r_c2, n_c2;

    logic                 mm_fin;
    logic                 kbit;
    logic [WORD_BITS-1:0] one;
    egd_pkg::t_state      next_bit;

    always_comb begin
        kbit     = r_k[WORD_BITS-1];
        one      = (i_p == WORD_BITS'(1)) ? '0 : WORD_BITS'(1);
        next_bit = (r_cnt == '0) ? egd_pkg::ST_LAST : egd_pkg::ST_SQ1;
    end

    always_comb begin
        n_state     = r_state;
        n_wait      = r_wait;
        n_cnt       = r_cnt;
        n_k         = r_k;
        n_m         = r_m;
        n_acc1      = r_acc1;
        n_acc2      = r_acc2;
        n_c2        = r_c2;
        o_in_ready  = 1'b0;
        o_res_valid = 1'b0;
        o_mm_start  = 1'b0;
        o_mm_a      = r_acc1;
        o_mm_b      = r_acc1;
        mm_fin      = 1'b0;

        if (r_state != egd_pkg::ST_IDLE && r_state != egd_pkg::ST_DONE) begin
            if (!r_wait) begin
                o_mm_start = 1'b1;
                n_wait     = 1'b1;
            end else if (i_mm_done) begin
                n_wait = 1'b0;
                mm_fin = 1'b1;
            end
        end

        unique case (r_state)
            egd_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_k    = i_k;
                    n_m    = i_m;
                    n_cnt  = CNT_W'(WORD_BITS - 1);
                    n_acc1 = (i_p == '0) ? '0 : one;
                    n_acc2 = one;
                    n_c2   = '0;
                    n_wait = 1'b0;
                    n_state = (i_p == '0) ? egd_pkg::ST_DONE : egd_pkg::ST_SQ1;
                end
            end
            egd_pkg::ST_SQ1: begin
                if (mm_fin) begin
                    n_acc1  = i_mm_result;
                    n_state = kbit ? egd_pkg::ST_MUL1 : egd_pkg::ST_SQ2;
                end
            end
            egd_pkg::ST_MUL1: begin
                o_mm_b = i_g;
                if (mm_fin) begin
                    n_acc1  = i_mm_result;
                    n_state = egd_pkg::ST_SQ2;
                end
            end
            egd_pkg::ST_SQ2: begin
                o_mm_a = r_acc2;
                o_mm_b = r_acc2;
                if (mm_fin) begin
                    n_acc2  = i_mm_result;
                    n_state = kbit ? egd_pkg::ST_MUL2 : next_bit;
                    if (!kbit) begin
                        n_cnt = r_cnt - 1'b1;
                        n_k   = {r_k[WORD_BITS-2:0], 1'b0};
                    end
                end
            end
            egd_pkg::ST_MUL2: begin
                o_mm_a = r_acc2;
                o_mm_b = i_y;
                if (mm_fin) begin
                    n_acc2  = i_mm_result;
                    n_state = next_bit;
                    n_cnt   = r_cnt - 1'b1;
                    n_k     = {r_k[WORD_BITS-2:0], 1'b0};
                end
            end
            egd_pkg::ST_LAST: begin
                o_mm_a = r_acc2;
                o_mm_b = r_m;
                if (mm_fin) begin
                    n_c2    = i_mm_result;
                    n_state = egd_pkg::ST_DONE;
                end
            end
            egd_pkg::ST_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = egd_pkg::ST_IDLE;
                end
            end
            default: n_state = egd_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= egd_pkg::ST_IDLE;
            r_wait  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wait  <= n_wait;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt  <= n_cnt;
        r_k    <= n_k;
        r_m    <= n_m;
        r_acc1 <= n_acc1;
        r_acc2 <= n_acc2;
        r_c2   <= n_c2;
    end

    assign o_c1 = r_acc1;
    assign o_c2 = r_c2;

endmodule

`default_nettype wire

// ----- rtl/core/egd_chk.sv -----
// Port-level checker for the ElGamal digit encryptor, bound to the top level.
`default_nettype none

module egd_chk #(
    parameter int unsigned WORD_BITS = 32
) (
    input wire logic                             i_clk,
    input wire logic                             i_rst_n,
    input wire logic                             i_s_axis_tvalid,
    input wire logic                             o_s_axis_tready,
    input wire logic                             o_m_axis_tvalid,
    input wire logic                             i_m_axis_tready,
    input wire logic [((2*WORD_BITS+7)/8)*8-1:0] o_m_axis_tdata
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("result changed while stalled");

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("input ready right after a transfer");

    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !$rose(o_m_axis_tvalid))
        else $error("result appeared one cycle after input");

    a_result_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> !$past(o_s_axis_tready))
        else $error("result appeared while idle");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

endmodule

bind elgamal_encrypt_digit egd_chk #(
    .WORD_BITS (WORD_BITS)
) u_egd_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

`default_nettype wire
